/* hw/rtl/nlrp_pkg.sv */
// Package for the note loop recorder and player: operation codes and the stored note record.
`default_nettype none

package nlrp_pkg;

  // Operation codes carried by each input item.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REC_ON = 3'd2,
    OP_REC_OFF = 3'd3,
    OP_MUTE   = 3'd4,
    OP_UNMUTE = 3'd5
  } op_e;

  // Attributes of one stored note.
  typedef struct packed {
    logic [3:0] chan;
    logic [6:0] vel;
    logic [6:0] pitch;
  } note_attr_t;

  // One stored note: start and end stamps relative to the record start.
  typedef struct packed {
    logic [31:0] start_ms;
    logic [31:0] end_ms;
    note_attr_t  attr;
  } note_rec_t;

endpackage

`default_nettype wire

/* hw/rtl/nlrp_store.sv */
// Note store: one write port and one registered read port.
`default_nettype none

module nlrp_store #(
  parameter  int MAX_NOTES = 256,
  localparam int IdxW      = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1
) (
  input  wire                          clk_i,
  input  wire                          wr_en_i,
  input  wire  [IdxW-1:0]              wr_addr_i,
  input  nlrp_pkg::note_rec_t          wr_data_i,
  input  wire  [IdxW-1:0]              rd_addr_i,
  output nlrp_pkg::note_rec_t          rd_data_o
);

  nlrp_pkg::note_rec_t mem_q [MAX_NOTES];
  nlrp_pkg::note_rec_t rd_data_q;

  // Entries are only ever used below the fill count, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hw/rtl/nlrp_ctrl.sv */
// Control: input register, recorder and player state, single-pass item logic and result register.
`default_nettype none

module nlrp_ctrl #(
  parameter  int MAX_NOTES = 256,
  localparam int IdxW      = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  output logic                 busy_o,
  input  wire  [2:0]           operation_i,
  input  wire  [31:0]          now_ms_i,
  input  wire  [31:0]          note_duration_i,
  input  wire  [6:0]           note_pitch_i,
  input  wire  [6:0]           note_velocity_i,
  input  wire  [3:0]           note_channel_i,
  output logic                 wr_en_o,
  output logic [IdxW-1:0]      wr_addr_o,
  output nlrp_pkg::note_rec_t  wr_data_o,
  output logic [IdxW-1:0]      rd_addr_o,
  input  nlrp_pkg::note_rec_t  rd_data_i,
  output logic                 done_o,
  output logic                 emit_event_o,
  output logic                 event_is_off_o,
  output logic [3:0]           event_channel_o,
  output logic [6:0]           event_pitch_o,
  output logic [6:0]           event_velocity_o,
  output logic                 is_recording_o,
  output logic                 is_muted_o,
  output logic [31:0]          loop_length_ms_o
);

  localparam int CntW = $clog2(MAX_NOTES + 1);
  localparam int PosW = $clog2(2 * MAX_NOTES + 1);

  // Input register.
  logic        in_vld_q;
  logic [2:0]  op_q;
  logic [31:0] now_q, dur_q;
  logic [6:0]  pitch_q, vel_q;
  logic [3:0]  chan_q;
  logic        ready_q;

  // Recorder and player state.
  logic [CntW-1:0] count_q, count_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            rec_q, rec_d;
  logic            mute_q, mute_d;
  logic [31:0]     rstart_q, rstart_d;
  logic [31:0]     pbstart_q, pbstart_d;
  logic [31:0]     len_q, len_d;

  // Per-item results.
  logic                 emit, is_off;
  nlrp_pkg::note_attr_t attr;
  logic                 wrap;
  logic [PosW-1:0]      cur_pos, rd_pos;
  logic [31:0]          cur_pb, stamp, due, rel;

  // Result register.
  logic                 done_q, emit_q, off_q, rec_out_q, mute_out_q;
  nlrp_pkg::note_attr_t attr_q;
  logic [31:0]          len_out_q;

  // The block is busy out of reset until ready_q is set, and ready from then on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
    end else begin
      ready_q <= 1'b1;
    end
  end
  assign busy_o = ~ready_q;

  // Capture an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i & ready_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && ready_q) begin
      op_q    <= operation_i;
      now_q   <= now_ms_i;
      dur_q   <= note_duration_i;
      pitch_q <= note_pitch_i;
      vel_q   <= note_velocity_i;
      chan_q  <= note_channel_i;
    end
  end

  // Work out the effect of the item held in the input register.
  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    rec_d     = rec_q;
    mute_d    = mute_q;
    rstart_d  = rstart_q;
    pbstart_d = pbstart_q;
    len_d     = len_q;
    emit      = 1'b0;
    is_off    = 1'b0;
    attr      = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = count_q[IdxW-1:0];
    rel       = now_q - rstart_q;
    wr_data_o = '{start_ms: rel, end_ms: rel + dur_q,
                  attr: '{chan: chan_q, vel: vel_q, pitch: pitch_q}};
    wrap      = (pos_q >= (PosW'(count_q) << 1));
    cur_pos   = wrap ? '0 : pos_q;
    cur_pb    = wrap ? now_q : pbstart_q;
    stamp     = cur_pos[0] ? rd_data_i.end_ms : rd_data_i.start_ms;
    due       = stamp + cur_pb;
    if (in_vld_q) begin
      unique case (op_q)
        nlrp_pkg::OP_TICK: begin
          if (!rec_q && !mute_q && (count_q != '0)) begin
            pbstart_d = cur_pb;
            pos_d     = cur_pos;
            if (due <= now_q) begin
              emit   = 1'b1;
              is_off = cur_pos[0];
              attr   = rd_data_i.attr;
              pos_d  = cur_pos + PosW'(1);
            end
          end
        end
        nlrp_pkg::OP_ADD: begin
          if (rec_q && (count_q < CntW'(MAX_NOTES))) begin
            wr_en_o = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        nlrp_pkg::OP_REC_ON: begin
          count_d  = '0;
          pos_d    = '0;
          mute_d   = 1'b1;
          rec_d    = 1'b1;
          rstart_d = now_q;
        end
        nlrp_pkg::OP_REC_OFF: begin
          rec_d     = 1'b0;
          mute_d    = 1'b0;
          pbstart_d = now_q;
          len_d     = rel;
        end
        nlrp_pkg::OP_MUTE: begin
          mute_d = 1'b1;
        end
        nlrp_pkg::OP_UNMUTE: begin
          mute_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Read ahead the note that the next tick will look at, from the state after this item.
  always_comb begin
    rd_pos    = (pos_d >= (PosW'(count_d) << 1)) ? '0 : pos_d;
    rd_addr_o = rd_pos[IdxW:1];
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pos_q     <= '0;
      rec_q     <= 1'b0;
      mute_q    <= 1'b1;
      rstart_q  <= '0;
      pbstart_q <= '0;
      len_q     <= '0;
    end else begin
      count_q   <= count_d;
      pos_q     <= pos_d;
      rec_q     <= rec_d;
      mute_q    <= mute_d;
      rstart_q  <= rstart_d;
      pbstart_q <= pbstart_d;
      len_q     <= len_d;
    end
  end

  // Result register: strobe for one cycle per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      emit_q     <= emit;
      off_q      <= is_off;
      attr_q     <= attr;
      rec_out_q  <= rec_d;
      mute_out_q <= mute_d;
      len_out_q  <= len_d;
    end
  end

  assign done_o           = done_q;
  assign emit_event_o     = emit_q;
  assign event_is_off_o   = off_q;
  assign event_channel_o  = attr_q.chan;
  assign event_pitch_o    = attr_q.pitch;
  assign event_velocity_o = attr_q.vel;
  assign is_recording_o   = rec_out_q;
  assign is_muted_o       = mute_out_q;
  assign loop_length_ms_o = len_out_q;

endmodule

`default_nettype wire

/* hw/rtl/note_loop_recorder_player_top.sv */
// Top level of the note loop recorder and player.
//
//   Channel   Signals                                   Handshake
//   command   operation_i now_ms_i note_duration_i      start_i high, busy_o low
//             note_pitch_i note_velocity_i note_channel_i
//   result    emit_event_o event_is_off_o event_*_o     done_o high for one cycle
//             is_recording_o is_muted_o loop_length_ms_o
//
// Every item gives one result via the input and result registers; one item
// can be accepted in every cycle while busy_o is low. The note store is read
// ahead, at the address that follows from the state the previous item leaves,
// so the tick logic finds its stamp already registered. busy_o is high only in
// the first cycle after reset. The receiver cannot stall; results are not held.
`default_nettype none

module note_loop_recorder_player_top #(
  parameter int MAX_NOTES = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [2:0]  operation_i,
  input  wire  [31:0] now_ms_i,
  input  wire  [31:0] note_duration_i,
  input  wire  [6:0]  note_pitch_i,
  input  wire  [6:0]  note_velocity_i,
  input  wire  [3:0]  note_channel_i,
  output logic        done_o,
  output logic        emit_event_o,
  output logic        event_is_off_o,
  output logic [3:0]  event_channel_o,
  output logic [6:0]  event_pitch_o,
  output logic [6:0]  event_velocity_o,
  output logic        is_recording_o,
  output logic        is_muted_o,
  output logic [31:0] loop_length_ms_o
);

  localparam int IdxW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

  logic                wr_en;
  logic [IdxW-1:0]     wr_addr, rd_addr;
  nlrp_pkg::note_rec_t wr_data, rd_data;

  // Note store.
  nlrp_store #(
    .MAX_NOTES (MAX_NOTES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Item logic and state.
  nlrp_ctrl #(
    .MAX_NOTES (MAX_NOTES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .now_ms_i         (now_ms_i),
    .note_duration_i  (note_duration_i),
    .note_pitch_i     (note_pitch_i),
    .note_velocity_i  (note_velocity_i),
    .note_channel_i   (note_channel_i),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .done_o           (done_o),
    .emit_event_o     (emit_event_o),
    .event_is_off_o   (event_is_off_o),
    .event_channel_o  (event_channel_o),
    .event_pitch_o    (event_pitch_o),
    .event_velocity_o (event_velocity_o),
    .is_recording_o   (is_recording_o),
    .is_muted_o       (is_muted_o),
    .loop_length_ms_o (loop_length_ms_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/nlrp_checker.sv */
// Port-level checker for the note loop recorder and player, bound to the top level.
`default_nettype none

module nlrp_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start_i,
  input wire        busy_o,
  input wire        done_o,
  input wire        emit_event_o,
  input wire        event_is_off_o,
  input wire [3:0]  event_channel_o,
  input wire [6:0]  event_pitch_o,
  input wire [6:0]  event_velocity_o,
  input wire        is_recording_o,
  input wire        is_muted_o
);

  // An accepted item gives its result once it has passed the input and result registers.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("accepted item gave no result");

  // No result appears unless an item was accepted to give it.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> ##1 !done_o)
    else $error("result without an accepted item");

  // A result that emits nothing carries cleared event fields.
  a_quiet_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !emit_event_o) |-> (!event_is_off_o && (event_channel_o == 4'd0) &&
                                   (event_pitch_o == 7'd0) && (event_velocity_o == 7'd0)))
    else $error("event fields set without an event");

  // Events are played only while neither recording nor muted.
  a_play_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && emit_event_o) |-> (!is_recording_o && !is_muted_o))
    else $error("event played while recording or muted");

endmodule

bind note_loop_recorder_player_top nlrp_checker u_nlrp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .emit_event_o     (emit_event_o),
  .event_is_off_o   (event_is_off_o),
  .event_channel_o  (event_channel_o),
  .event_pitch_o    (event_pitch_o),
  .event_velocity_o (event_velocity_o),
  .is_recording_o   (is_recording_o),
  .is_muted_o       (is_muted_o)
);

`default_nettype wire
